// File: rtl/ttce_pkg.sv
// Shared types, constants and pixel encoders for the tiled texture copy encoder.
package ttce_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned COORD_W = 10;
    localparam int unsigned ARGB_W  = 32;
    localparam int unsigned STRIDE_W = 20;
    localparam int unsigned FMT_W   = 4;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned PROD_W  = 28;
    localparam int unsigned OFF_W   = 14;

    localparam int unsigned BUF_WIDTH  = 640;
    localparam int unsigned BUF_HEIGHT = 528;
    localparam logic [COORD_W:0] BUF_W_LIM = (COORD_W + 1)'(BUF_WIDTH);
    localparam logic [COORD_W:0] BUF_H_LIM = (COORD_W + 1)'(BUF_HEIGHT);

    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [ADDR_W-1:0] PAIR_GAP = ADDR_W'(32);

    // register indexes
    localparam logic [IDX_W-1:0] REG_DEST_ADDR   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW_STRIDE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_RECT_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_TEX_FORMAT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SRC_X       = 3'd5;
    localparam logic [IDX_W-1:0] REG_SRC_Y       = 3'd6;

    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = STRIDE_W'(1280);

    // texture format codes
    localparam logic [FMT_W-1:0] FMT_I4     = 4'h0;
    localparam logic [FMT_W-1:0] FMT_I8     = 4'h1;
    localparam logic [FMT_W-1:0] FMT_IA4    = 4'h2;
    localparam logic [FMT_W-1:0] FMT_IA8    = 4'h3;
    localparam logic [FMT_W-1:0] FMT_RGB565 = 4'h4;
    localparam logic [FMT_W-1:0] FMT_RGB5A3 = 4'h5;
    localparam logic [FMT_W-1:0] FMT_RGBA8  = 4'h6;
    localparam logic [FMT_W-1:0] FMT_R8     = 4'h8;
    localparam logic [FMT_W-1:0] FMT_G8     = 4'h9;
    localparam logic [FMT_W-1:0] FMT_B8     = 4'hA;
    localparam logic [FMT_W-1:0] FMT_RG8    = 4'hB;
    localparam logic [FMT_W-1:0] FMT_GB8    = 4'hC;

    typedef struct packed {
        logic [ADDR_W-1:0]   dest_addr;
        logic [STRIDE_W-1:0] row_stride;
        logic [COORD_W-1:0]  rect_width;
        logic [COORD_W-1:0]  rect_height;
        logic [FMT_W-1:0]    tex_format;
        logic [COORD_W-1:0]  src_x;
        logic [COORD_W-1:0]  src_y;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data0;
        logic [DATA_W-1:0] data1;
        logic              two;
        logic              pair;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   drop;
        entry_t entry;
    } front_out_t;

    function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        logic [15:0] sum;
        sum = {8'b0, r} * 16'd77 + {8'b0, g} * 16'd151 + {8'b0, b} * 16'd28;
        return sum[15:8];
    endfunction

    function automatic logic [DATA_W-1:0] encode16(input logic [FMT_W-1:0] fmt,
                                                   input logic [ARGB_W-1:0] argb);
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [DATA_W-1:0] v;
        a = argb[31:24];
        r = argb[23:16];
        g = argb[15:8];
        b = argb[7:0];
        unique case (fmt)
            FMT_RGB565: v = {r[7:3], g[7:2], b[7:3]};
            FMT_RGB5A3:
            begin
                if (a >= 8'hE0)
                    v = {1'b1, r[7:3], g[7:3], b[7:3]};
                else
                    v = {1'b0, a[7:5], r[7:4], g[7:4], b[7:4]};
            end
            FMT_RG8: v = {r, g};
            FMT_GB8: v = {g, b};
            default: v = {a, luma(r, g, b)};
        endcase
        return v;
    endfunction

endpackage

// File: rtl/tiled_texture_copy_encoder.sv
// With an empty queue the first write goes through the front-end stage register, the queue and
// the back-end output register; the RGBA8 second write follows from the pending register.
// Throughput: one write per cycle from the back end while requests are queued; one pixel per
// cycle for one-write formats while not busy; RGBA8 takes two writes on the single port.
// busy rises when all 8 queue slots are reserved; strobe cannot be held off by the receiver.
// Reset clears the queue, the pipeline and the slot count, and sets the registers to defaults.
module tiled_texture_copy_encoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ttce_pkg::COORD_W-1:0] pix_x,
    input  logic [ttce_pkg::COORD_W-1:0] pix_y,
    input  logic [ttce_pkg::ARGB_W-1:0]  pixel_argb,
    input  logic                         cfg_we,
    input  logic [ttce_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ttce_pkg::ADDR_W-1:0]  cfg_data,
    output logic                         strobe,
    output logic [ttce_pkg::ADDR_W-1:0]  write_addr,
    output logic [ttce_pkg::DATA_W-1:0]  write_data,
    output logic                         two_bytes,
    output logic                         last
);
    import ttce_pkg::*;

    cfg_t              cfg_reg;
    logic [QCNT_W-1:0] used_reg;
    logic [QCNT_W-1:0] used_next;
    logic              accept;
    front_out_t        fo;
    entry_t            head;
    logic              empty;
    logic              full;
    logic              pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_addr   <= '0;
            cfg_reg.row_stride  <= ROW_STRIDE_RST;
            cfg_reg.rect_width  <= '0;
            cfg_reg.rect_height <= '0;
            cfg_reg.tex_format  <= FMT_I4;
            cfg_reg.src_x       <= '0;
            cfg_reg.src_y       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEST_ADDR:   cfg_reg.dest_addr   <= cfg_data;
                REG_ROW_STRIDE:  cfg_reg.row_stride  <= cfg_data[STRIDE_W-1:0];
                REG_RECT_WIDTH:  cfg_reg.rect_width  <= cfg_data[COORD_W-1:0];
                REG_RECT_HEIGHT: cfg_reg.rect_height <= cfg_data[COORD_W-1:0];
                REG_TEX_FORMAT:  cfg_reg.tex_format  <= cfg_data[FMT_W-1:0];
                REG_SRC_X:       cfg_reg.src_x       <= cfg_data[COORD_W-1:0];
                REG_SRC_Y:       cfg_reg.src_y       <= cfg_data[COORD_W-1:0];
                default:         cfg_reg.src_y       <= cfg_reg.src_y;
            endcase
        end
    end

    // reserve a queue slot per accepted pixel; release on drop or pop
    always_comb
    begin
        busy      = (used_reg == QCNT_W'(QDEPTH));
        accept    = start && !busy;
        used_next = used_reg + QCNT_W'(accept) - QCNT_W'(fo.drop) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= '0;
        else
            used_reg <= used_next;
    end

    ttce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .pixel_argb (pixel_argb),
        .cfg        (cfg_reg),
        .fo         (fo)
    );

    ttce_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fo.push),
        .din   (fo.entry),
        .pop   (pop),
        .head  (head),
        .empty (empty),
        .full  (full)
    );

    ttce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .strobe     (strobe),
        .write_addr (write_addr),
        .write_data (write_data),
        .two_bytes  (two_bytes),
        .last       (last)
    );

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= QCNT_W'(QDEPTH))
        else $error("slot count above queue depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fo.push && full && !pop))
        else $error("push into full queue");

    a_push_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !(fo.push && fo.drop))
        else $error("pixel both pushed and dropped");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && last && two_bytes)
        else $error("second half of pair missing");

    a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !two_bytes |-> write_data[15:8] == 8'h00)
        else $error("single-byte write with high byte set");
`endif

endmodule

// File: rtl/ttce_front.sv
// Front end: checks a pixel, encodes it and forms its tiled address.
module ttce_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [ttce_pkg::COORD_W-1:0] pix_x,
    input  logic [ttce_pkg::COORD_W-1:0] pix_y,
    input  logic [ttce_pkg::ARGB_W-1:0]  pixel_argb,
    input  ttce_pkg::cfg_t              cfg,
    output ttce_pkg::front_out_t        fo
);
    import ttce_pkg::*;

    logic                narrow;
    logic                rgba;
    logic                in_range;
    logic [COORD_W:0]    buf_x;
    logic [COORD_W:0]    buf_y;
    logic [7:0]          tiles8;
    logic [8:0]          tiles4;
    logic [STRIDE_W-1:0] row_bytes;
    logic [OFF_W-1:0]    off;
    logic [7:0]          narrow_val;
    logic [DATA_W-1:0]   data0;
    logic [DATA_W-1:0]   data1;
    logic [COORD_W:0]    cw_pad8;
    logic [COORD_W:0]    cw_pad4;

    logic                s1_valid_reg;
    logic                s1_keep_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic [OFF_W-1:0]    s1_off_reg;
    logic [DATA_W-1:0]   s1_data0_reg;
    logic [DATA_W-1:0]   s1_data1_reg;
    logic                s1_two_reg;
    logic                s1_pair_reg;

    always_comb
    begin
        narrow = (cfg.tex_format == FMT_I8) || (cfg.tex_format == FMT_IA4) ||
                 (cfg.tex_format == FMT_R8) || (cfg.tex_format == FMT_G8) ||
                 (cfg.tex_format == FMT_B8);
        rgba = (cfg.tex_format == FMT_RGBA8);

        buf_x = {1'b0, cfg.src_x} + {1'b0, pix_x};
        buf_y = {1'b0, cfg.src_y} + {1'b0, pix_y};
        in_range = (cfg.dest_addr != '0) && (cfg.tex_format != FMT_I4) &&
                   (pix_x < cfg.rect_width) && (pix_y < cfg.rect_height) &&
                   (buf_x < BUF_W_LIM) && (buf_y < BUF_H_LIM);

        // row_stride if nonzero, else packed tile row length from the rounded-up tile count
        cw_pad8 = {1'b0, cfg.rect_width} + (COORD_W + 1)'(7);
        cw_pad4 = {1'b0, cfg.rect_width} + (COORD_W + 1)'(3);
        tiles8 = cw_pad8[COORD_W:3];
        tiles4 = cw_pad4[COORD_W:2];
        priority if (cfg.row_stride != '0)
            row_bytes = cfg.row_stride;
        else if (narrow)
            row_bytes = STRIDE_W'({tiles8, 5'b0});
        else if (rgba)
            row_bytes = STRIDE_W'({tiles4, 6'b0});
        else
            row_bytes = STRIDE_W'({tiles4, 5'b0});

        // tile base within the row plus texel offset within the tile
        priority if (narrow)
            off = OFF_W'({pix_x[9:3], pix_y[1:0], pix_x[2:0]});
        else if (rgba)
            off = {pix_x[9:2], 1'b0, pix_y[1:0], pix_x[1:0], 1'b0};
        else
            off = OFF_W'({pix_x[9:2], pix_y[1:0], pix_x[1:0], 1'b0});

        unique case (cfg.tex_format)
            FMT_R8:  narrow_val = pixel_argb[23:16];
            FMT_G8:  narrow_val = pixel_argb[15:8];
            FMT_B8:  narrow_val = pixel_argb[7:0];
            default: narrow_val = luma(pixel_argb[23:16], pixel_argb[15:8], pixel_argb[7:0]);
        endcase

        priority if (narrow)
            data0 = {8'b0, narrow_val};
        else if (rgba)
            data0 = pixel_argb[31:16];
        else
            data0 = encode16(cfg.tex_format, pixel_argb);
        data1 = pixel_argb[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_keep_reg  <= in_range;
            s1_prod_reg  <= PROD_W'(pix_y[9:2]) * PROD_W'(row_bytes);
            s1_off_reg   <= off;
            s1_data0_reg <= data0;
            s1_data1_reg <= data1;
            s1_two_reg   <= !narrow;
            s1_pair_reg  <= rgba;
        end
    end

    always_comb
    begin
        fo.push        = s1_valid_reg && s1_keep_reg;
        fo.drop        = s1_valid_reg && !s1_keep_reg;
        fo.entry.addr  = cfg.dest_addr + ADDR_W'(s1_prod_reg) + ADDR_W'(s1_off_reg);
        fo.entry.data0 = s1_data0_reg;
        fo.entry.data1 = s1_data1_reg;
        fo.entry.two   = s1_two_reg;
        fo.entry.pair  = s1_pair_reg;
    end

endmodule

// File: rtl/ttce_queue.sv
// Short request queue between the front end and the write back end.
module ttce_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ttce_pkg::entry_t din,
    input  logic             pop,
    output ttce_pkg::entry_t head,
    output logic             empty,
    output logic             full
);
    import ttce_pkg::*;

    entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    always_comb
    begin
        empty    = (cnt_reg == '0);
        full     = (cnt_reg == QCNT_W'(QDEPTH));
        head     = mem_reg[rd_ptr_reg];
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

// File: rtl/ttce_back.sv
// Back end: drains queued requests and issues one write of one or two bytes per cycle.
module ttce_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ttce_pkg::entry_t            head,
    input  logic                        empty,
    output logic                        pop,
    output logic                        strobe,
    output logic [ttce_pkg::ADDR_W-1:0] write_addr,
    output logic [ttce_pkg::DATA_W-1:0] write_data,
    output logic                        two_bytes,
    output logic                        last
);
    import ttce_pkg::*;

    logic              strobe_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;
    logic              two_reg;
    logic              last_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [DATA_W-1:0] pend_data_reg;

    // hold the queue while the second half of a pair goes out
    assign pop = !pend_reg && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= pend_reg || !empty;
            if (pend_reg)
                pend_reg <= 1'b0;
            else if (!empty)
                pend_reg <= head.pair;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            addr_reg <= pend_addr_reg;
            data_reg <= pend_data_reg;
            two_reg  <= 1'b1;
            last_reg <= 1'b1;
        end
        else if (!empty)
        begin
            addr_reg      <= head.addr;
            data_reg      <= head.data0;
            two_reg       <= head.two;
            last_reg      <= !head.pair;
            pend_addr_reg <= head.addr + PAIR_GAP;
            pend_data_reg <= head.data1;
        end
    end

    assign strobe     = strobe_reg;
    assign write_addr = addr_reg;
    assign write_data = data_reg;
    assign two_bytes  = two_reg;
    assign last       = last_reg;

endmodule

// File: tb/tiled_texture_copy_encoder_tb.sv
// Self-checking testbench for the tiled texture copy encoder: directed and random pixels, predicted writes.
`timescale 1ns / 1ps

module tiled_texture_copy_encoder_tb;
    import ttce_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ARGB_W-1:0]  argb;
    } pixel_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              two;
        logic              last;
    } texel_write_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [COORD_W-1:0]  pix_x = '0;
    logic [COORD_W-1:0]  pix_y = '0;
    logic [ARGB_W-1:0]   pixel_argb = '0;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [ADDR_W-1:0]   cfg_data = '0;
    logic                strobe;
    logic [ADDR_W-1:0]   write_addr;
    logic [DATA_W-1:0]   write_data;
    logic                two_bytes;
    logic                last;

    pixel_req_t   pixel_queue[$];
    texel_write_t writes_due[$];
    pixel_req_t   next_pixel;
    texel_write_t oldest_write;
    cfg_t         shadow_cfg;
    logic         req_taken = 1'b0;
    int           sender_idle_pct = 21;
    int           error_count = 0;
    int           pixels_taken = 0;
    int           writes_seen = 0;
    int           settings_count = 1;

    tiled_texture_copy_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .pixel_argb (pixel_argb),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .strobe     (strobe),
        .write_addr (write_addr),
        .write_data (write_data),
        .two_bytes  (two_bytes),
        .last       (last)
    );

    always #4 clk = ~clk;

    function automatic void set_defaults();
        shadow_cfg = '0;
        shadow_cfg.row_stride = ROW_STRIDE_RST;
    endfunction

    function automatic void queue_write(input logic [ADDR_W-1:0] addr,
                                        input logic [DATA_W-1:0] data,
                                        input logic two, input logic fin);
        texel_write_t w;
        w.addr = addr;
        w.data = data;
        w.two  = two;
        w.last = fin;
        writes_due.push_back(w);
    endfunction

    // Work out the byte writes one pixel causes under the current settings.
    function automatic void predict_texel(input cfg_t c, input pixel_req_t p);
        logic [7:0]        a;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        logic [7:0]        lum;
        logic [7:0]        one_byte;
        logic [DATA_W-1:0] word;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] row_bytes;
        int unsigned       px;
        int unsigned       py;
        int unsigned       sum;
        int unsigned       tw;
        int unsigned       tile_size;
        int unsigned       t;
        bit                narrow;
        a = p.argb[31:24];
        r = p.argb[23:16];
        g = p.argb[15:8];
        b = p.argb[7:0];
        px = 32'(p.x);
        py = 32'(p.y);
        if (c.dest_addr == '0 || c.tex_format == FMT_I4)
            return;
        if (px >= c.rect_width || py >= c.rect_height)
            return;
        if (c.src_x + px >= BUF_WIDTH || c.src_y + py >= BUF_HEIGHT)
            return;
        case (c.tex_format)
            FMT_I8, FMT_IA4, FMT_R8, FMT_G8, FMT_B8: narrow = 1'b1;
            default: narrow = 1'b0;
        endcase
        tw = narrow ? 8 : 4;
        tile_size = (c.tex_format == FMT_RGBA8) ? 64 : 32;
        if (c.row_stride != '0)
            row_bytes = ADDR_W'(c.row_stride);
        else
            row_bytes = ((c.rect_width + tw - 1) / tw) * tile_size;
        base = c.dest_addr + (py / 4) * row_bytes + (px / tw) * tile_size;
        t = (py % 4) * tw + (px % tw);
        sum = (r * 77 + g * 151 + b * 28) >> 8;
        lum = sum[7:0];
        if (c.tex_format == FMT_RGBA8)
        begin
            queue_write(base + 2 * t, p.argb[31:16], 1'b1, 1'b0);
            queue_write(base + PAIR_GAP + 2 * t, p.argb[15:0], 1'b1, 1'b1);
            return;
        end
        if (narrow)
        begin
            case (c.tex_format)
                FMT_R8: one_byte = r;
                FMT_G8: one_byte = g;
                FMT_B8: one_byte = b;
                default: one_byte = lum;
            endcase
            queue_write(base + t, {8'h00, one_byte}, 1'b0, 1'b1);
            return;
        end
        case (c.tex_format)
            FMT_RGB565: word = {r[7:3], g[7:2], b[7:3]};
            FMT_RGB5A3:
            begin
                if (a >= 8'hE0)
                    word = {1'b1, r[7:3], g[7:3], b[7:3]};
                else
                    word = {1'b0, a[7:5], r[7:4], g[7:4], b[7:4]};
            end
            FMT_RG8: word = {r, g};
            FMT_GB8: word = {g, b};
            default: word = {a, lum};
        endcase
        queue_write(base + 2 * t, word, 1'b1, 1'b1);
    endfunction

    // Driver: advance to the next request once the current one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!start || req_taken))
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_pixel = pixel_queue.pop_front();
                start      <= 1'b1;
                pix_x      <= next_pixel.x;
                pix_y      <= next_pixel.y;
                pixel_argb <= next_pixel.argb;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: track register writes, predict on acceptance, check each strobe.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            set_defaults();
            req_taken <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEST_ADDR:   shadow_cfg.dest_addr   = cfg_data;
                    REG_ROW_STRIDE:  shadow_cfg.row_stride  = cfg_data[STRIDE_W-1:0];
                    REG_RECT_WIDTH:  shadow_cfg.rect_width  = cfg_data[COORD_W-1:0];
                    REG_RECT_HEIGHT: shadow_cfg.rect_height = cfg_data[COORD_W-1:0];
                    REG_TEX_FORMAT:  shadow_cfg.tex_format  = cfg_data[FMT_W-1:0];
                    REG_SRC_X:       shadow_cfg.src_x       = cfg_data[COORD_W-1:0];
                    REG_SRC_Y:       shadow_cfg.src_y       = cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
            if (strobe)
            begin
                writes_seen++;
                if (writes_due.size() == 0)
                begin
                    $error("write with nothing expected: addr %h data %h",
                           write_addr, write_data);
                    error_count++;
                end
                else
                begin
                    oldest_write = writes_due.pop_front();
                    if (write_addr !== oldest_write.addr)
                    begin
                        $error("write_addr: expected %h, got %h", oldest_write.addr, write_addr);
                        error_count++;
                    end
                    if (write_data !== oldest_write.data)
                    begin
                        $error("write_data: expected %h, got %h", oldest_write.data, write_data);
                        error_count++;
                    end
                    if (two_bytes !== oldest_write.two)
                    begin
                        $error("two_bytes: expected %b, got %b", oldest_write.two, two_bytes);
                        error_count++;
                    end
                    if (last !== oldest_write.last)
                    begin
                        $error("last: expected %b, got %b", oldest_write.last, last);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_texel(shadow_cfg, {pix_x, pix_y, pixel_argb});
                pixels_taken++;
            end
            req_taken <= start && !busy;
        end
    end

    task automatic queue_pixel(input int x, input int y, input logic [ARGB_W-1:0] argb);
        pixel_req_t p;
        p.x = COORD_W'(x);
        p.y = COORD_W'(y);
        p.argb = argb;
        pixel_queue.push_back(p);
    endtask

    // Hold until every request is taken and every write has come, then let the pipe empty.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || start || writes_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    // Called at a falling edge; leaves cfg_we high for the caller to drop.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic pick_settings(input int phase);
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] stride;
        logic [ADDR_W-1:0] wid;
        logic [ADDR_W-1:0] hgt;
        logic [ADDR_W-1:0] sx;
        logic [ADDR_W-1:0] sy;
        logic [FMT_W-1:0]  fmt;
        fmt = (phase < 16) ? FMT_W'(phase) : FMT_W'($urandom_range((1 << FMT_W) - 1));
        case ($urandom_range(9))
            0: dest = '0;
            1: dest = 32'hFFFF_FF00 | $urandom_range(255);
            2: dest = '1;
            default: dest = $urandom;
        endcase
        case ($urandom_range(3))
            0: stride = '0;
            1: stride = (1 << STRIDE_W) - 1;
            2: stride = $urandom_range(64) * 32;
            default: stride = $urandom_range((1 << STRIDE_W) - 1);
        endcase
        case ($urandom_range(7))
            0: wid = '0;
            1: wid = (1 << COORD_W) - 1;
            2: wid = $urandom_range((1 << COORD_W) - 1, 1);
            default: wid = $urandom_range(40, 1);
        endcase
        case ($urandom_range(7))
            0: hgt = '0;
            1: hgt = (1 << COORD_W) - 1;
            2: hgt = $urandom_range((1 << COORD_W) - 1, 1);
            default: hgt = $urandom_range(40, 1);
        endcase
        case ($urandom_range(5))
            0: sx = (1 << COORD_W) - 1;
            1: sx = $urandom_range(BUF_WIDTH - 1, BUF_WIDTH - 40);
            2: sx = $urandom_range((1 << COORD_W) - 1);
            default: sx = $urandom_range(40);
        endcase
        case ($urandom_range(5))
            0: sy = (1 << COORD_W) - 1;
            1: sy = $urandom_range(BUF_HEIGHT - 1, BUF_HEIGHT - 40);
            2: sy = $urandom_range((1 << COORD_W) - 1);
            default: sy = $urandom_range(40);
        endcase
        write_reg(REG_DEST_ADDR, dest);
        write_reg(REG_ROW_STRIDE, stride);
        write_reg(REG_RECT_WIDTH, wid);
        write_reg(REG_RECT_HEIGHT, hgt);
        write_reg(REG_TEX_FORMAT, ADDR_W'(fmt));
        write_reg(REG_SRC_X, sx);
        write_reg(REG_SRC_Y, sy);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    function automatic logic [ARGB_W-1:0] random_argb();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return {8'hE0, 24'($urandom)};
            3: return {8'hDF, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Mostly pixels that land inside rectangle and buffer; the rest anywhere.
    task automatic queue_random_pixels(input int count);
        int lim_x;
        int lim_y;
        int x;
        int y;
        lim_x = (shadow_cfg.src_x < BUF_WIDTH) ? BUF_WIDTH - shadow_cfg.src_x : 0;
        lim_y = (shadow_cfg.src_y < BUF_HEIGHT) ? BUF_HEIGHT - shadow_cfg.src_y : 0;
        if (shadow_cfg.rect_width < lim_x)
            lim_x = shadow_cfg.rect_width;
        if (shadow_cfg.rect_height < lim_y)
            lim_y = shadow_cfg.rect_height;
        repeat (count)
        begin
            if (lim_x > 0 && lim_y > 0 && $urandom_range(99) < 80)
            begin
                x = $urandom_range(lim_x - 1);
                y = $urandom_range(lim_y - 1);
            end
            else
            begin
                x = $urandom_range((1 << COORD_W) - 1);
                y = $urandom_range((1 << COORD_W) - 1);
            end
            queue_pixel(x, y, random_argb());
        end
    endtask

    initial
    begin
        set_defaults();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: destination zero, nothing may be written.
        queue_pixel(0, 0, 32'hFFFF_FFFF);
        queue_pixel(5, 3, 32'h1234_5678);
        wait_drained();

        // Row stride and source offsets stay at their reset values here.
        write_reg(REG_DEST_ADDR, 32'hFFFF_FFF0);
        write_reg(REG_RECT_WIDTH, (1 << COORD_W) - 1);
        write_reg(REG_RECT_HEIGHT, (1 << COORD_W) - 1);
        write_reg(REG_TEX_FORMAT, ADDR_W'(FMT_RGB5A3));
        cfg_we <= 1'b0;
        settings_count++;
        queue_pixel(0, 0, 32'h0000_0000);
        queue_pixel(0, 0, 32'hFFFF_FFFF);
        queue_pixel(1, 0, 32'hE0FF_FFFF);
        queue_pixel(2, 1, 32'hDFFF_FFFF);
        queue_pixel(7, 9, 32'hE012_3456);
        queue_pixel(BUF_WIDTH - 1, BUF_HEIGHT - 1, 32'hDF80_4020);
        queue_pixel(BUF_WIDTH, 0, 32'hFFFF_FFFF);
        queue_pixel(0, BUF_HEIGHT, 32'hFFFF_FFFF);
        queue_pixel((1 << COORD_W) - 1, (1 << COORD_W) - 1, 32'hFFFF_FFFF);
        queue_pixel(513, 341, 32'hA5C3_3C5A);
        wait_drained();

        // RGBA8 with packed rows, a narrow rectangle clipped by the buffer edge.
        write_reg(REG_TEX_FORMAT, ADDR_W'(FMT_RGBA8));
        write_reg(REG_ROW_STRIDE, '0);
        write_reg(REG_RECT_WIDTH, 5);
        write_reg(REG_RECT_HEIGHT, 6);
        write_reg(REG_SRC_X, BUF_WIDTH - 4);
        write_reg(REG_SRC_Y, BUF_HEIGHT - 6);
        cfg_we <= 1'b0;
        settings_count++;
        queue_pixel(0, 0, 32'h0102_0304);
        queue_pixel(3, 3, 32'hFFFF_FFFF);
        queue_pixel(3, 5, 32'h8899_AABB);
        queue_pixel(2, 4, 32'h0000_0000);
        queue_pixel(4, 0, 32'hFFFF_FFFF);
        queue_pixel(0, 6, 32'hFFFF_FFFF);
        queue_pixel(5, 1, 32'hFFFF_FFFF);
        queue_pixel(1, 2, 32'h7F80_01FE);
        wait_drained();

        // Random settings; the first sixteen walk every format code.
        for (int phase = 0; phase < 24; phase++)
        begin
            sender_idle_pct = (phase >= 8 && phase < 12) ? 0 : 21;
            pick_settings(phase);
            queue_random_pixels(50);
            wait_drained();
        end

        if (writes_due.size() != 0)
        begin
            $error("%0d writes never arrived", writes_due.size());
            error_count++;
        end
        $display("Covered %0d pixel requests under %0d register settings, all 16 format codes,",
                 pixels_taken, settings_count);
        $display("and checked %0d texel writes field by field.", writes_seen);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/ttce_pkg.sv
rtl/ttce_front.sv
rtl/ttce_queue.sv
rtl/ttce_back.sv
rtl/tiled_texture_copy_encoder.sv
tb/tiled_texture_copy_encoder_tb.sv
